// ----- hw/rtl/wavp_pkg.sv -----
// Shared types, chunk IDs, status codes and helpers for the WAV header parser.
// Used by wavp_front, wavp_queue, wavp_back and the wav_header_parser top level.
`timescale 1ns / 1ps

package wavp_pkg;

    // Chunk IDs as they read in file order (big-endian view of four bytes).
    localparam logic [31:0] ID_RIFF = 32'h52494646;
    localparam logic [31:0] ID_WAVE = 32'h57415645;
    localparam logic [31:0] ID_FMT  = 32'h666D7420;
    localparam logic [31:0] ID_DATA = 32'h64617461;
    localparam logic [31:0] ID_FACT = 32'h66616374;

    // Format values that the header must carry.
    localparam logic [15:0] FMT_TAG_PCM   = 16'h0001;
    localparam logic [15:0] BITS_16       = 16'd16;
    localparam logic [31:0] FMT_LEN_PLAIN = 32'd16;

    // Offset of the first sample: 36 + 8 without a fact chunk, 46 + 8 + length with one.
    localparam logic [32:0] OFFSET_PLAIN     = 33'd44;
    localparam logic [32:0] OFFSET_FACT_BASE = 33'd54;

    // Milliseconds per second and the number of restoring division steps.
    localparam int DUR_SCALE = 1000;
    localparam int NUM_W     = 42;
    localparam int DUR_W     = 41;
    localparam int DIV_STEPS = NUM_W;

    // Result status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_RIFF  = 4'd1;
    localparam logic [3:0] ST_BAD_WAVE  = 4'd2;
    localparam logic [3:0] ST_BAD_FMT   = 4'd3;
    localparam logic [3:0] ST_NOT_PCM   = 4'd4;
    localparam logic [3:0] ST_NOT_16BIT = 4'd5;
    localparam logic [3:0] ST_BAD_EXTRA = 4'd6;
    localparam logic [3:0] ST_BAD_FACT  = 4'd7;
    localparam logic [3:0] ST_BAD_DATA  = 4'd8;

    // One parsed header, handed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] riff_size;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [31:0] data_size;
        logic [32:0] data_offset;
    } job_t;

    // Reverse the byte order of a word assembled little endian.
    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ----- hw/rtl/wavp_front.sv -----
// Byte-level front end: walks the RIFF/WAVE header one accepted byte per cycle and
// emits at most one job per file. Depends on wavp_pkg.
`timescale 1ns / 1ps

module wavp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_accept,
    input  logic [7:0]       byte_value,
    input  logic             start_of_file,
    output logic             job_push,
    output wavp_pkg::job_t   job
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_SKIP = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // Header byte positions at which a field completes.
    localparam logic [5:0] POS_RIFF_ID  = 6'd3;
    localparam logic [5:0] POS_RIFF_SZ  = 6'd7;
    localparam logic [5:0] POS_WAVE_ID  = 6'd11;
    localparam logic [5:0] POS_FMT_ID   = 6'd15;
    localparam logic [5:0] POS_FMT_LEN  = 6'd19;
    localparam logic [5:0] POS_FMT_TAG  = 6'd21;
    localparam logic [5:0] POS_CHANNELS = 6'd23;
    localparam logic [5:0] POS_RATE     = 6'd27;
    localparam logic [5:0] POS_BYTERATE = 6'd31;
    localparam logic [5:0] POS_ALIGN    = 6'd33;
    localparam logic [5:0] POS_BITS     = 6'd35;
    localparam logic [5:0] POS_EXTRA    = 6'd37;
    localparam logic [5:0] POS_FACT_ID  = 6'd41;
    localparam logic [5:0] POS_FACT_LEN = 6'd45;

    // Positions inside the data chunk header.
    localparam logic [2:0] REL_DATA_ID = 3'd3;
    localparam logic [2:0] REL_DATA_SZ = 3'd7;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [2:0]  rel_reg, rel_next;
    logic [31:0] asm_reg, asm_next;
    logic        extra_reg, extra_next;
    logic [31:0] fact_len_reg, fact_len_next;
    logic [31:0] skip_cnt_reg, skip_cnt_next;
    logic [31:0] riff_reg, riff_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;

    phase_t      cur_phase;
    logic [5:0]  cur_pos;
    logic [31:0] word;
    logic        fail;
    logic [3:0]  fail_code;
    logic        done;

    // Next-state logic for one accepted byte.
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        rel_next      = rel_reg;
        asm_next      = asm_reg;
        extra_next    = extra_reg;
        fact_len_next = fact_len_reg;
        skip_cnt_next = skip_cnt_reg;
        riff_next     = riff_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        brate_next    = brate_reg;
        align_next    = align_reg;
        fail          = 1'b0;
        fail_code     = wavp_pkg::ST_OK;
        done          = 1'b0;

        cur_phase = start_of_file ? PH_HEAD : phase_reg;
        cur_pos   = start_of_file ? 6'd0 : pos_reg;
        word      = {byte_value, asm_reg[31:8]};

        if (byte_accept && (start_of_file || phase_reg != PH_IDLE)) begin
            asm_next   = word;
            phase_next = cur_phase;
            unique case (cur_phase)
                PH_HEAD: begin
                    pos_next = cur_pos + 6'd1;
                    unique case (cur_pos)
                        POS_RIFF_ID: begin
                            if (wavp_pkg::swap32(word) != wavp_pkg::ID_RIFF) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_BAD_RIFF;
                            end
                        end
                        POS_RIFF_SZ: riff_next = word;
                        POS_WAVE_ID: begin
                            if (wavp_pkg::swap32(word) != wavp_pkg::ID_WAVE) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_BAD_WAVE;
                            end
                        end
                        POS_FMT_ID: begin
                            if (wavp_pkg::swap32(word) != wavp_pkg::ID_FMT) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_BAD_FMT;
                            end
                        end
                        POS_FMT_LEN: extra_next = (word != wavp_pkg::FMT_LEN_PLAIN);
                        POS_FMT_TAG: begin
                            if (word[31:16] != wavp_pkg::FMT_TAG_PCM) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_NOT_PCM;
                            end
                        end
                        POS_CHANNELS: chan_next  = word[31:16];
                        POS_RATE:     rate_next  = word;
                        POS_BYTERATE: brate_next = word;
                        POS_ALIGN:    align_next = word[31:16];
                        POS_BITS: begin
                            if (word[31:16] != wavp_pkg::BITS_16) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_NOT_16BIT;
                            end else if (!extra_reg) begin
                                phase_next = PH_DATA;
                                rel_next   = 3'd0;
                            end
                        end
                        POS_EXTRA: begin
                            if (word[31:16] != 16'd0) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_BAD_EXTRA;
                            end
                        end
                        POS_FACT_ID: begin
                            if (wavp_pkg::swap32(word) != wavp_pkg::ID_FACT) begin
                                fail      = 1'b1;
                                fail_code = wavp_pkg::ST_BAD_FACT;
                            end
                        end
                        POS_FACT_LEN: begin
                            fact_len_next = word;
                            skip_cnt_next = word;
                            rel_next      = 3'd0;
                            phase_next    = (word == 32'd0) ? PH_DATA : PH_SKIP;
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    // The last byte of the fact body hands over to the data chunk.
                    if (skip_cnt_reg == 32'd1) begin
                        phase_next = PH_DATA;
                        rel_next   = 3'd0;
                    end else begin
                        skip_cnt_next = skip_cnt_reg - 32'd1;
                    end
                end
                PH_DATA: begin
                    rel_next = rel_reg + 3'd1;
                    if (rel_reg == REL_DATA_ID &&
                        wavp_pkg::swap32(word) != wavp_pkg::ID_DATA) begin
                        fail      = 1'b1;
                        fail_code = wavp_pkg::ST_BAD_DATA;
                    end else if (rel_reg == REL_DATA_SZ) begin
                        done = 1'b1;
                    end
                end
                default: ;
            endcase

            if (fail || done) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Job assembly: an error carries only its status, a good file all fields.
    always_comb begin
        job      = '0;
        job_push = fail || done;
        if (fail) begin
            job.status = fail_code;
        end else begin
            job.status        = wavp_pkg::ST_OK;
            job.riff_size     = riff_reg;
            job.num_channels  = chan_reg;
            job.sample_rate   = rate_reg;
            job.byte_rate     = brate_reg;
            job.block_align   = align_reg;
            job.data_size     = word;
            job.data_offset   = extra_reg ?
                                (wavp_pkg::OFFSET_FACT_BASE + {1'b0, fact_len_reg}) :
                                wavp_pkg::OFFSET_PLAIN;
        end
    end

    // Parse phase is the only control state that needs a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Positions, assembly word and captured fields.
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        rel_reg      <= rel_next;
        asm_reg      <= asm_next;
        extra_reg    <= extra_next;
        fact_len_reg <= fact_len_next;
        skip_cnt_reg <= skip_cnt_next;
        riff_reg     <= riff_next;
        chan_reg     <= chan_next;
        rate_reg     <= rate_next;
        brate_reg    <= brate_next;
        align_reg    <= align_next;
    end

endmodule

// ----- hw/rtl/wavp_queue.sv -----
// Two-entry job queue between the header front end and the duration back end.
// Depends on wavp_pkg for the job type.
`timescale 1ns / 1ps

module wavp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wavp_pkg::job_t   din,
    input  logic             pop,
    output wavp_pkg::job_t   dout,
    output logic             not_empty,
    output logic             full
);

    wavp_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    // Occupancy flags and head entry.
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign dout      = entry_reg[rd_ptr_reg];

    // Pointer and count updates.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hw/rtl/wavp_back.sv -----
// Back end: takes one job, works out the playing time with a bit-serial
// restoring divider and holds the result for the output channel. Depends on wavp_pkg.
`timescale 1ns / 1ps

module wavp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    input  wavp_pkg::job_t   job,
    output logic             job_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_status,
    output logic [31:0]      m_riff_size,
    output logic [15:0]      m_num_channels,
    output logic [31:0]      m_sample_rate,
    output logic [31:0]      m_byte_rate,
    output logic [15:0]      m_block_align,
    output logic [31:0]      m_data_size,
    output logic [32:0]      m_data_offset,
    output logic [40:0]      m_duration_ms
);

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_DIV  = 4'b0100,
        BK_HOLD = 4'b1000
    } back_state_t;

    localparam logic [5:0] LAST_STEP = 6'(wavp_pkg::DIV_STEPS - 1);

    back_state_t                    state_reg, state_next;
    wavp_pkg::job_t                 job_reg, job_next;
    logic [wavp_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [31:0]                    div_reg, div_next;
    logic [31:0]                    rem_reg, rem_next;
    logic [5:0]                     cnt_reg, cnt_next;

    logic [47:0]                    rate_prod;
    logic [wavp_pkg::NUM_W-1:0]     scaled_size;
    logic [32:0]                    rem_shift;
    logic                           rem_ge;
    logic [32:0]                    rem_diff;

    // Divisor is rate * 2 * channels kept to 32 bits; dividend is 1000 * data size.
    assign rate_prod   = job_reg.sample_rate * job_reg.num_channels;
    assign scaled_size = {10'd0, job_reg.data_size} *
                         wavp_pkg::NUM_W'(wavp_pkg::DUR_SCALE);

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, num_reg[wavp_pkg::NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        job_pop    = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_pop  = 1'b1;
                    job_next = job;
                    num_next = '0;
                    if (job.status == wavp_pkg::ST_OK) begin
                        state_next = BK_MUL;
                    end else begin
                        state_next = BK_HOLD;
                    end
                end
            end
            BK_MUL: begin
                num_next = scaled_size;
                div_next = {rate_prod[30:0], 1'b0};
                rem_next = '0;
                cnt_next = '0;
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (div_reg == 32'd0) begin
                    // A zero divisor gives a zero playing time.
                    num_next   = '0;
                    state_next = BK_HOLD;
                end else begin
                    num_next = {num_reg[wavp_pkg::NUM_W-2:0], rem_ge};
                    rem_next = rem_ge ? rem_diff[31:0] : rem_shift[31:0];
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == LAST_STEP) begin
                        state_next = BK_HOLD;
                    end
                end
            end
            BK_HOLD: begin
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // The held result drives the output channel.
    assign m_valid         = (state_reg == BK_HOLD);
    assign m_status        = job_reg.status;
    assign m_riff_size     = job_reg.riff_size;
    assign m_num_channels  = job_reg.num_channels;
    assign m_sample_rate   = job_reg.sample_rate;
    assign m_byte_rate     = job_reg.byte_rate;
    assign m_block_align   = job_reg.block_align;
    assign m_data_size     = job_reg.data_size;
    assign m_data_offset   = job_reg.data_offset;
    assign m_duration_ms   = num_reg[wavp_pkg::DUR_W-1:0];

endmodule

// ----- hw/rtl/wav_header_parser.sv -----
// Top level of the WAV header parser: front end, job queue and back end.
// Depends on wavp_pkg, wavp_front, wavp_queue and wavp_back.
`timescale 1ns / 1ps

// WAV header parser.
// Input channel (s_): one file byte per item, s_start_of_file marks byte 0 of
// a file and restarts any parse in progress. Bytes outside a parse are dropped.
// Output channel (m_): at most one item per file, after the data size or at the first
// failed check. On an error only m_status is nonzero.
// Throughput: the front end takes one byte per cycle while the two-entry job
// queue has room. s_ready drops only when both queue entries are in use.
// Path: a good file's job passes through the queue, then a state that loads the
// job, one that registers the two multiplies, and 42 steps of the bit-serial
// divider that forms the playing time. An error job goes from the load straight
// to the held result, and a file whose divisor is zero leaves the divider at once.
// A stalled receiver holds the result on m_ and the back end waits; the front
// end keeps taking bytes until the queue is full.
// Reset (aresetn low, synchronous) empties the queue, drops any held result
// and puts the front end back to waiting for a start of file.
module wav_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [31:0] m_riff_size,
    output logic [15:0] m_num_channels,
    output logic [31:0] m_sample_rate,
    output logic [31:0] m_byte_rate,
    output logic [15:0] m_block_align,
    output logic [31:0] m_data_size,
    output logic [32:0] m_data_offset,
    output logic [40:0] m_duration_ms
);

    logic           byte_accept;
    logic           job_push;
    wavp_pkg::job_t job_in;
    wavp_pkg::job_t job_head;
    logic           job_avail;
    logic           job_pop;
    logic           queue_full;

    // Bytes are taken whenever the queue can absorb a job.
    assign s_ready     = !queue_full;
    assign byte_accept = s_valid && s_ready;

    wavp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_accept   (byte_accept),
        .byte_value    (s_byte_value),
        .start_of_file (s_start_of_file),
        .job_push      (job_push),
        .job           (job_in)
    );

    wavp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .din       (job_in),
        .pop       (job_pop),
        .dout      (job_head),
        .not_empty (job_avail),
        .full      (queue_full)
    );

    wavp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (job_avail),
        .job             (job_head),
        .job_pop         (job_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_riff_size     (m_riff_size),
        .m_num_channels  (m_num_channels),
        .m_sample_rate   (m_sample_rate),
        .m_byte_rate     (m_byte_rate),
        .m_block_align   (m_block_align),
        .m_data_size     (m_data_size),
        .m_data_offset   (m_data_offset),
        .m_duration_ms   (m_duration_ms)
    );

endmodule

// ----- hw/rtl/wavp_checker.sv -----
// Port-level checks for wav_header_parser and the bind that attaches them.
// Depends on wavp_pkg for the status codes.
`timescale 1ns / 1ps

module wavp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic [31:0] m_riff_size,
    input logic [15:0] m_num_channels,
    input logic [31:0] m_sample_rate,
    input logic [31:0] m_byte_rate,
    input logic [15:0] m_block_align,
    input logic [31:0] m_data_size,
    input logic [32:0] m_data_offset,
    input logic [40:0] m_duration_ms
);

    // A stalled result item stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_size) &&
            $stable(m_data_offset) && $stable(m_duration_ms))
        else $error("result changed while stalled");

    // An error item carries nothing but its status.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != wavp_pkg::ST_OK |->
            m_riff_size == 32'd0 && m_num_channels == 16'd0 && m_sample_rate == 32'd0 &&
            m_byte_rate == 32'd0 && m_block_align == 16'd0 && m_data_size == 32'd0 &&
            m_data_offset == 33'd0 && m_duration_ms == 41'd0)
        else $error("error item with nonzero fields");

    // A good file starts its samples after the plain header or after a fact chunk.
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == wavp_pkg::ST_OK |->
            m_data_offset == wavp_pkg::OFFSET_PLAIN ||
            m_data_offset >= wavp_pkg::OFFSET_FACT_BASE)
        else $error("bad data offset");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind wav_header_parser wavp_checker u_wavp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_riff_size     (m_riff_size),
    .m_num_channels  (m_num_channels),
    .m_sample_rate   (m_sample_rate),
    .m_byte_rate     (m_byte_rate),
    .m_block_align   (m_block_align),
    .m_data_size     (m_data_size),
    .m_data_offset   (m_data_offset),
    .m_duration_ms   (m_duration_ms)
);

// ----- sim/tb_wav_header_parser.sv -----
// Self-checking testbench for wav_header_parser: streams WAV files byte by byte
// and checks every header item against a byte-level parser model kept here.
// Depends on wavp_pkg (status codes, chunk IDs, format constants) and the RTL.
`timescale 1ns / 1ps

module tb_wav_header_parser;

    localparam int unsigned TOTAL_BYTES  = 1950;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 60;

    // One expected header item, as it appears on the m_ ports.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] riff_size;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [31:0] data_size;
        logic [32:0] data_offset;
        logic [40:0] duration_ms;
    } header_result_t;

    // Contents of one generated file header, field by field.
    typedef struct {
        logic [31:0] riff_id;
        logic [31:0] riff_size;
        logic [31:0] wave_id;
        logic [31:0] fmt_id;
        logic [31:0] fmt_len;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [31:0] byte_rate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [15:0] extra_size;
        logic [31:0] fact_id;
        logic [31:0] fact_len;
        logic [31:0] data_id;
        logic [31:0] data_size;
    } wav_header_t;

    typedef enum logic [3:0] {
        WAIT_START   = 4'b0001,
        IN_HEADER    = 4'b0010,
        IN_FACT_BODY = 4'b0100,
        IN_DATA_HDR  = 4'b1000
    } parse_state_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'd0;
    logic        s_start_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [31:0] m_riff_size;
    logic [15:0] m_num_channels;
    logic [31:0] m_sample_rate;
    logic [31:0] m_byte_rate;
    logic [15:0] m_block_align;
    logic [31:0] m_data_size;
    logic [32:0] m_data_offset;
    logic [40:0] m_duration_ms;

    // Parser model state.
    parse_state_t parse_state;
    logic [32:0]  byte_pos;
    logic [31:0]  le_word;
    logic [31:0]  id_word;
    logic         fact_path;
    logic [31:0]  fact_len;
    logic [31:0]  cap_riff_size;
    logic [15:0]  cap_channels;
    logic [31:0]  cap_rate;
    logic [31:0]  cap_byte_rate;
    logic [15:0]  cap_align;
    logic [31:0]  cap_data_size;

    header_result_t pending_results[$];
    logic [7:0]     file_bytes[$];

    int unsigned error_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    bit          sender_gaps  = 1'b1;

    wav_header_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_start_of_file (s_start_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_riff_size     (m_riff_size),
        .m_num_channels  (m_num_channels),
        .m_sample_rate   (m_sample_rate),
        .m_byte_rate     (m_byte_rate),
        .m_block_align   (m_block_align),
        .m_data_size     (m_data_size),
        .m_data_offset   (m_data_offset),
        .m_duration_ms   (m_duration_ms)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Return the model to its power-on state.
    function automatic void clear_parser();
        parse_state   = WAIT_START;
        byte_pos      = '0;
        le_word       = '0;
        id_word       = '0;
        fact_path     = 1'b0;
        fact_len      = '0;
        cap_riff_size = '0;
        cap_channels  = '0;
        cap_rate      = '0;
        cap_byte_rate = '0;
        cap_align     = '0;
        cap_data_size = '0;
    endfunction

    // Advance the model by one accepted byte. The values are kept little endian
    // in le_word, while IDs are compared in file order through id_word.
    function automatic void parse_byte(input logic [7:0] value, input logic sof,
                                       output bit done, output header_result_t res);
        logic [32:0] p;
        logic [32:0] data_hdr_pos;
        logic [32:0] rel;
        logic [31:0] divisor;
        logic [63:0] scaled;
        logic [3:0]  fail_code;
        done = 1'b0;
        res = '0;
        fail_code = wavp_pkg::ST_OK;
        if (sof) begin
            clear_parser();
            parse_state = IN_HEADER;
        end else if (parse_state == WAIT_START) begin
            return;
        end
        p = byte_pos;
        byte_pos = p + 33'd1;
        le_word = {value, le_word[31:8]};
        id_word = {id_word[23:0], value};
        data_hdr_pos = fact_path ? 33'd46 + fact_len : 33'd36;

        case (parse_state)
            IN_HEADER: begin
                // Each field is complete at the offset of its last byte.
                case (p)
                    33'd3:  if (id_word != wavp_pkg::ID_RIFF) fail_code = wavp_pkg::ST_BAD_RIFF;
                    33'd7:  cap_riff_size = le_word;
                    33'd11: if (id_word != wavp_pkg::ID_WAVE) fail_code = wavp_pkg::ST_BAD_WAVE;
                    33'd15: if (id_word != wavp_pkg::ID_FMT) fail_code = wavp_pkg::ST_BAD_FMT;
                    33'd19: fact_path = (le_word != wavp_pkg::FMT_LEN_PLAIN);
                    33'd21: begin
                        if (le_word[31:16] != wavp_pkg::FMT_TAG_PCM)
                            fail_code = wavp_pkg::ST_NOT_PCM;
                    end
                    33'd23: cap_channels = le_word[31:16];
                    33'd27: cap_rate = le_word;
                    33'd31: cap_byte_rate = le_word;
                    33'd33: cap_align = le_word[31:16];
                    33'd35: begin
                        if (le_word[31:16] != wavp_pkg::BITS_16)
                            fail_code = wavp_pkg::ST_NOT_16BIT;
                        else if (!fact_path) parse_state = IN_DATA_HDR;
                    end
                    33'd37: if (le_word[31:16] != 16'd0) fail_code = wavp_pkg::ST_BAD_EXTRA;
                    33'd41: if (id_word != wavp_pkg::ID_FACT) fail_code = wavp_pkg::ST_BAD_FACT;
                    33'd45: begin
                        fact_len = le_word;
                        if (le_word == 32'd0) parse_state = IN_DATA_HDR;
                        else parse_state = IN_FACT_BODY;
                    end
                    default: ;
                endcase
            end
            IN_FACT_BODY: begin
                if (p >= 33'd45 + fact_len) parse_state = IN_DATA_HDR;
            end
            default: begin
                rel = p - data_hdr_pos;
                if (rel == 33'd3 && id_word != wavp_pkg::ID_DATA) begin
                    fail_code = wavp_pkg::ST_BAD_DATA;
                end else if (rel >= 33'd7) begin
                    cap_data_size = le_word;
                    done = 1'b1;
                end
            end
        endcase

        // A failed check reports only its status; a good header reports everything.
        if (fail_code != wavp_pkg::ST_OK) begin
            done = 1'b1;
            res.status = fail_code;
        end else if (done) begin
            res.status        = wavp_pkg::ST_OK;
            res.riff_size     = cap_riff_size;
            res.num_channels  = cap_channels;
            res.sample_rate   = cap_rate;
            res.byte_rate     = cap_byte_rate;
            res.block_align   = cap_align;
            res.data_size     = cap_data_size;
            res.data_offset   = data_hdr_pos + 33'd8;
            divisor = cap_rate * 32'd2 * {16'd0, cap_channels};
            scaled = 64'd1000 * cap_data_size;
            if (divisor != 32'd0) begin
                scaled = scaled / divisor;
                res.duration_ms = scaled[40:0];
            end
        end
        if (done) parse_state = WAIT_START;
    endfunction

    // Send one byte, with an idle gap first when gaps are enabled and the current burst has run out.
    task automatic send_byte(input logic [7:0] value, input logic sof);
        int unsigned    gap;
        bit             done;
        header_result_t res;
        if (sender_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_valid         <= 1'b1;
        s_byte_value    <= value;
        s_start_of_file <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(value, sof, done, res);
        bytes_sent++;
        if (done) pending_results.push_back(res);
        @(negedge aclk);
    endtask

    // Hold the input side until every expected header item has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(id[8*i +: 8]);
    endfunction

    // Lay out a header in file order; the extra word and fact chunk follow the
    // format block whenever the format length is not the plain one.
    function automatic void build_file(input wav_header_t h);
        file_bytes.delete();
        push_id(h.riff_id);
        push_le(h.riff_size, 4);
        push_id(h.wave_id);
        push_id(h.fmt_id);
        push_le(h.fmt_len, 4);
        push_le({16'd0, h.format_tag}, 2);
        push_le({16'd0, h.channels}, 2);
        push_le(h.rate, 4);
        push_le(h.byte_rate, 4);
        push_le({16'd0, h.align}, 2);
        push_le({16'd0, h.bits}, 2);
        if (h.fmt_len != wavp_pkg::FMT_LEN_PLAIN) begin
            push_le({16'd0, h.extra_size}, 2);
            push_id(h.fact_id);
            push_le(h.fact_len, 4);
            for (longint i = 0; i < h.fact_len; i++)
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        push_id(h.data_id);
        push_le(h.data_size, 4);
    endfunction

    // Send a file, optionally cut short, followed by optional trailing bytes.
    task automatic send_file(input wav_header_t h, input int cut_len, input int tail_len);
        int n;
        build_file(h);
        n = (cut_len > 0 && cut_len < file_bytes.size()) ? cut_len : file_bytes.size();
        for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0);
        repeat (tail_len) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // A well-formed 16-bit stereo file of ten seconds at 44.1 kHz.
    function automatic wav_header_t pcm_header();
        wav_header_t h;
        h.riff_id    = wavp_pkg::ID_RIFF;
        h.riff_size  = 32'd1764036;
        h.wave_id    = wavp_pkg::ID_WAVE;
        h.fmt_id     = wavp_pkg::ID_FMT;
        h.fmt_len    = wavp_pkg::FMT_LEN_PLAIN;
        h.format_tag = wavp_pkg::FMT_TAG_PCM;
        h.channels   = 16'd2;
        h.rate       = 32'd44100;
        h.byte_rate  = 32'd176400;
        h.align      = 16'd4;
        h.bits       = wavp_pkg::BITS_16;
        h.extra_size = 16'd0;
        h.fact_id    = wavp_pkg::ID_FACT;
        h.fact_len   = 32'd0;
        h.data_id    = wavp_pkg::ID_DATA;
        h.data_size  = 32'd1764000;
        return h;
    endfunction

    function automatic logic [31:0] flip_bit(input logic [31:0] v);
        return v ^ (32'd1 << $urandom_range(0, 31));
    endfunction

    // Break the one check that yields the given status.
    function automatic wav_header_t corrupt(input wav_header_t h, input logic [3:0] code);
        wav_header_t c;
        c = h;
        case (code)
            wavp_pkg::ST_BAD_RIFF: c.riff_id = flip_bit(c.riff_id);
            wavp_pkg::ST_BAD_WAVE: c.wave_id = flip_bit(c.wave_id);
            wavp_pkg::ST_BAD_FMT:  c.fmt_id = flip_bit(c.fmt_id);
            wavp_pkg::ST_NOT_PCM: begin
                do c.format_tag = 16'($urandom);
                while (c.format_tag == wavp_pkg::FMT_TAG_PCM);
            end
            wavp_pkg::ST_NOT_16BIT: begin
                do c.bits = 16'($urandom); while (c.bits == wavp_pkg::BITS_16);
            end
            wavp_pkg::ST_BAD_EXTRA: begin
                if (c.fmt_len == wavp_pkg::FMT_LEN_PLAIN) c.fmt_len = 32'd18;
                c.extra_size = 16'($urandom_range(1, 16'hFFFF));
            end
            wavp_pkg::ST_BAD_FACT: begin
                if (c.fmt_len == wavp_pkg::FMT_LEN_PLAIN) c.fmt_len = 32'd18;
                c.fact_id = flip_bit(c.fact_id);
            end
            wavp_pkg::ST_BAD_DATA: c.data_id = flip_bit(c.data_id);
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly sensible headers with random values, a quarter of them broken.
    function automatic wav_header_t random_header();
        wav_header_t h;
        logic [31:0] w;
        h = pcm_header();
        h.riff_size = random_word();
        w = random_word();
        h.channels = ($urandom_range(0, 3) == 0) ? w[15:0] : 16'($urandom_range(1, 8));
        case ($urandom_range(0, 5))
            0: h.rate = 32'd8000;
            1: h.rate = 32'd22050;
            2: h.rate = 32'd48000;
            3: h.rate = 32'd96000;
            default: h.rate = random_word();
        endcase
        w = random_word();
        h.align = ($urandom_range(0, 1) == 0) ? h.channels * 16'd2 : w[15:0];
        h.byte_rate = ($urandom_range(0, 1) == 0) ? h.rate * h.align : random_word();
        h.data_size = random_word();
        case ($urandom_range(0, 4))
            0: h.fmt_len = random_word();
            1: h.fmt_len = 32'd18;
            default: h.fmt_len = wavp_pkg::FMT_LEN_PLAIN;
        endcase
        h.fact_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            h = corrupt(h, 4'($urandom_range(wavp_pkg::ST_BAD_RIFF, wavp_pkg::ST_BAD_DATA)));
        return h;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each delivered header item with the oldest one predicted.
    always @(posedge aclk) begin
        header_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("header item with status %0d arrived with none predicted", m_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_status);
                check_field("riff_size", want.riff_size, m_riff_size);
                check_field("num_channels", want.num_channels, m_num_channels);
                check_field("sample_rate", want.sample_rate, m_sample_rate);
                check_field("byte_rate", want.byte_rate, m_byte_rate);
                check_field("block_align", want.block_align, m_block_align);
                check_field("data_size", want.data_size, m_data_size);
                check_field("data_offset", want.data_offset, m_data_offset);
                check_field("duration_ms", want.duration_ms, m_duration_ms);
            end
        end
    end

    // Receiver: runs of ready and stall, with long open and long blocked spells.
    int unsigned ready_run   = 0;
    logic        ready_level = 1'b1;
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    ready_level = 1'b0;
                    ready_run = $urandom_range(20, 60);
                end
                1, 2: begin
                    ready_level = 1'b1;
                    ready_run = $urandom_range(100, 300);
                end
                default: begin
                    ready_level = 1'($urandom_range(0, 1));
                    ready_run = $urandom_range(1, 8);
                end
            endcase
        end
        ready_run--;
        m_ready <= ready_level;
    end

    // Watchdog: give up when neither side has moved an item for too long.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Bytes without a start marker after reset must be dropped silently.
    task automatic test_ignored_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        push_id(wavp_pkg::ID_RIFF);
        file_bytes.delete();
        send_byte(8'h52, 1'b0);
        send_byte(8'h49, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(8'h46, 1'b0);
    endtask

    // A plain file back to back without gaps, then again with trailing junk.
    task automatic test_plain_file();
        sender_gaps = 1'b0;
        send_file(pcm_header(), 0, 0);
        send_file(pcm_header(), 0, 0);
        sender_gaps = 1'b1;
        send_file(pcm_header(), 0, 6);
    endtask

    // Format lengths other than 16 pull in the extra word and a fact chunk.
    task automatic test_fact_chunk();
        wav_header_t h;
        h = pcm_header();
        h.fmt_len = 32'd18;
        send_file(h, 0, 0);
        h.fmt_len = 32'd20;
        h.fact_len = 32'd4;
        send_file(h, 0, 0);
        h.fmt_len = 32'hFFFF_FFFF;
        h.fact_len = 32'd1;
        send_file(h, 0, 0);
        h.fmt_len = 32'd0;
        h.fact_len = 32'd37;
        send_file(h, 0, 0);
    endtask

    // One broken file per status code, plus a bad data ID behind a fact chunk and a nonzero extra size.
    task automatic test_status_codes();
        wav_header_t h;
        for (int code = wavp_pkg::ST_BAD_RIFF; code <= wavp_pkg::ST_BAD_DATA; code++)
            send_file(corrupt(pcm_header(), 4'(code)), 0, 0);
        h = pcm_header();
        h.fmt_len = 32'd18;
        h.fact_len = 32'd2;
        send_file(corrupt(h, wavp_pkg::ST_BAD_DATA), 0, 0);
        h = pcm_header();
        h.fmt_len = 32'd18;
        h.extra_size = 16'hFFFF;
        send_file(h, 0, 0);
    endtask

    // Divisor of zero, directly and through the 32-bit wrap of rate * 2 * channels.
    task automatic test_zero_divisor();
        wav_header_t h;
        h = pcm_header();
        h.rate = 32'd0;
        send_file(h, 0, 0);
        h = pcm_header();
        h.channels = 16'd0;
        send_file(h, 0, 0);
        h = pcm_header();
        h.rate = 32'h8000_0000;
        h.channels = 16'd1;
        send_file(h, 0, 0);
        h.rate = 32'h4000_0000;
        h.channels = 16'd2;
        send_file(h, 0, 0);
    endtask

    // All ones, all zeros and the longest possible duration.
    task automatic test_field_extremes();
        wav_header_t h;
        h = pcm_header();
        h.riff_size = 32'hFFFF_FFFF;
        h.channels  = 16'hFFFF;
        h.rate      = 32'hFFFF_FFFF;
        h.byte_rate = 32'hFFFF_FFFF;
        h.align     = 16'hFFFF;
        h.data_size = 32'hFFFF_FFFF;
        h.fmt_len   = 32'hFFFF_FFFF;
        send_file(h, 0, 0);
        h = pcm_header();
        h.riff_size = 32'd0;
        h.byte_rate = 32'd0;
        h.align     = 16'd0;
        h.data_size = 32'd0;
        send_file(h, 0, 0);
        h.rate      = 32'd1;
        h.channels  = 16'd1;
        h.data_size = 32'hFFFF_FFFF;
        send_file(h, 0, 0);
    endtask

    // A start marker in the middle of a file abandons it without an item.
    task automatic test_restart();
        wav_header_t h;
        send_file(pcm_header(), 20, 0);
        send_file(pcm_header(), 1, 0);
        send_file(pcm_header(), 43, 0);
        h = pcm_header();
        h.fmt_len = 32'd18;
        h.fact_len = 32'd10;
        send_file(h, 50, 0);
        send_file(h, 0, 0);
        wait_for_results();
    endtask

    // Random files until the byte budget is spent: mostly well formed, some
    // broken, cut short or followed by junk.
    task automatic test_random_files();
        int unsigned files;
        int          cut;
        int          tail;
        files = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            if (files % 12 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
            cut = 0;
            tail = 0;
            case ($urandom_range(0, 9))
                0: cut = $urandom_range(1, 50);
                1: tail = $urandom_range(1, 10);
                default: ;
            endcase
            send_file(random_header(), cut, tail);
            files++;
            if ($urandom_range(0, 15) == 0) wait_for_results();
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        clear_parser();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_ignored_bytes();
        test_plain_file();
        test_fact_chunk();
        test_status_codes();
        test_zero_divisor();
        test_field_extremes();
        test_restart();
        test_random_files();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted header items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
